// ----- hdl/dsmw_pkg.sv -----
// ----------------------------------------------------------------------------
// dsmw_pkg: shared definitions for the decimal segment matrix writer
// Store size, item kinds, sequencer states and the seven-segment code table.
// ----------------------------------------------------------------------------
package dsmw_pkg;

	// Default number of digit positions in the store.
	localparam int DSMW_DIGITS = 8;

	// Number of segment rows, and so of column transactions per show item.
	localparam int DSMW_ROWS = 8;

	// Reciprocal of ten scaled by 2^35; exact quotient for every 32-bit value.
	localparam logic [31:0] DSMW_RECIP10 = 32'hCCCC_CCCD;
	localparam int          DSMW_RECIP_SHIFT = 35;

	// Item kinds.
	localparam logic KIND_SHOW  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_EMIT
	} dsmw_state_t;

	// Seven-segment code, bit 0 = segment a up to bit 6 = segment g.
	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0:    code = 8'h3F;
			4'd1:    code = 8'h06;
			4'd2:    code = 8'h5B;
			4'd3:    code = 8'h4F;
			4'd4:    code = 8'h66;
			4'd5:    code = 8'h6D;
			4'd6:    code = 8'h7D;
			4'd7:    code = 8'h07;
			4'd8:    code = 8'h7F;
			4'd9:    code = 8'h6F;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

// ----- hdl/dsmw_div10.sv -----
// ----------------------------------------------------------------------------
// dsmw_div10: divide-by-ten unit
// Splits a 32-bit value into its quotient by ten and its lowest decimal digit.
// ----------------------------------------------------------------------------
module dsmw_div10 (
	input  logic [31:0] dividend,
	output logic [31:0] quotient,
	output logic [3:0]  remainder
);
	import dsmw_pkg::*;

	logic [63:0] product;
	logic [3:0]  q_times_ten;

	// Multiply by the scaled reciprocal; the high bits are the exact quotient.
	assign product  = {32'd0, dividend} * {32'd0, DSMW_RECIP10};
	assign quotient = 32'(product >> DSMW_RECIP_SHIFT);

	// The remainder is below ten, so only the low four bits of v - 10q matter.
	assign q_times_ten = {quotient[0], 3'b000} + {quotient[2:0], 1'b0};
	assign remainder   = dividend[3:0] - q_times_ten;

endmodule

// ----- hdl/decimal_segment_matrix_writer.sv -----
// ----------------------------------------------------------------------------
// decimal_segment_matrix_writer: decimal number to seven-segment column bytes
// Converts a number to decimal digits into a digit store, then streams the
// store transposed into eight column bytes for a segment-matrix display.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------
//  in      | sink      | in_valid / in_ready | kind, start_digit, leading_zeros,
//          |           |                     | digit_count, value
//  out     | source    | out_valid/out_ready | grid_address, segment_column, last
//
// A show transaction is accepted while idle, then runs its digits through the
// shared divide-by-ten unit (one digit per cycle), then loads the eight column
// bytes one at a time into the output register, each once that register is
// free or being taken. A clear transaction empties the store on acceptance.
// The block has a single divide-by-ten unit and a single output register.
// Reset clears the digit store, the sequencer and the output valid flag.
// A stalled sink holds the column sequence; in_ready is high only while idle,
// and a new item may be accepted while the last column still waits.
// ----------------------------------------------------------------------------
module decimal_segment_matrix_writer #(
	parameter int DIGITS = dsmw_pkg::DSMW_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [2:0]  start_digit,
	input  logic        leading_zeros,
	input  logic [3:0]  digit_count,
	input  logic [31:0] value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  grid_address,
	output logic [7:0]  segment_column,
	output logic        last
);
	import dsmw_pkg::*;

	localparam int ROW_W = $clog2(DSMW_ROWS);

	// Sequencer state.
	dsmw_state_t state_q, state_d;

	// Working registers of the digit loop.
	logic [31:0]      val_q;
	logic             lz_q;
	logic [3:0]       left_q;
	logic [4:0]       pos_q;
	logic [ROW_W-1:0] row_q;

	// The digit store itself.
	logic [7:0] store_q [DIGITS];

	// Output register.
	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [7:0]       out_col_q;

	// Control from the output decoder.
	logic accept;
	logic do_digit;
	logic load_out;

	// Divider results and the code for the current digit.
	logic [31:0] quotient;
	logic [3:0]  remainder;
	logic [7:0]  digit_code;
	logic [7:0]  column;

	dsmw_div10 u_div10 (
		.dividend  (val_q),
		.quotient  (quotient),
		.remainder (remainder)
	);

	// Blanking looks at the value that remains before this digit is taken, so
	// a zero value with leading zeros off leaves every written position blank.
	assign digit_code = (lz_q || (val_q != 32'd0)) ? seg_code(remainder) : 8'h00;

	// Transpose: bit 7-j of the column is bit row of digit j; positions that
	// the store does not hold read as zero.
	for (genvar j = 0; j < DSMW_ROWS; j++) begin : g_col
		if (j < DIGITS) begin : g_held
			assign column[DSMW_ROWS-1-j] = store_q[j][row_q];
		end else begin : g_empty
			assign column[DSMW_ROWS-1-j] = 1'b0;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && (kind == KIND_SHOW)) begin
					state_d = (digit_count != 4'd0) ? ST_DIGIT : ST_EMIT;
				end
			end
			ST_DIGIT: begin
				if (left_q == 4'd1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load_out && (row_q == ROW_W'(DSMW_ROWS - 1))) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decoder of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		do_digit = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_DIGIT: do_digit = 1'b1;
			ST_EMIT:  load_out = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int p = 0; p < DIGITS; p++) begin
				store_q[p] <= 8'h00;
			end
		end else begin
			state_q <= state_d;

			if (accept && (kind == KIND_CLEAR)) begin
				for (int p = 0; p < DIGITS; p++) begin
					store_q[p] <= 8'h00;
				end
			end

			// Positions at or above the store size are dropped, but the
			// division still moves on to the next digit.
			if (do_digit) begin
				for (int p = 0; p < DIGITS; p++) begin
					if (pos_q == 5'(p)) begin
						store_q[p] <= digit_code;
					end
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= value;
			lz_q   <= leading_zeros;
			left_q <= digit_count;
			// Least significant digit lands at start + count - 1.
			pos_q  <= {2'b00, start_digit} + {1'b0, digit_count} - 5'd1;
			row_q  <= '0;
		end else begin
			if (do_digit) begin
				val_q  <= quotient;
				left_q <= left_q - 4'd1;
				pos_q  <= pos_q - 5'd1;
			end
			if (load_out) begin
				row_q <= row_q + ROW_W'(1);
			end
		end

		if (load_out) begin
			out_row_q <= row_q;
			out_col_q <= column;
		end
	end

	assign out_valid      = out_valid_q;
	assign grid_address   = {out_row_q, 1'b0};
	assign segment_column = out_col_q;
	assign last           = (out_row_q == ROW_W'(DSMW_ROWS - 1));

endmodule

// ----- tb/dsmw_column_checker.sv -----
// ----------------------------------------------------------------------------
// dsmw_column_checker: column prediction and comparison for the matrix writer
// Mirrors the digit store from every accepted input transaction, queues the
// eight column bytes that each show item must produce and compares every
// accepted output transaction with the oldest queued column.
// ----------------------------------------------------------------------------
module dsmw_column_checker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        kind,
	input  logic [2:0]  start_digit,
	input  logic        leading_zeros,
	input  logic [3:0]  digit_count,
	input  logic [31:0] value,

	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  grid_address,
	input  logic [7:0]  segment_column,
	input  logic        last,

	output int          mismatch_count,
	output int          pending_columns
);
	import dsmw_pkg::*;

	typedef struct packed {
		logic [3:0] grid;
		logic [7:0] column;
		logic       last;
	} column_word_t;

	// Segment patterns for the digits 0 to 9, segment a in bit 0.
	localparam logic [7:0] SEGMENT_PATTERN [0:9] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	logic [7:0]   digit_image [0:DSMW_DIGITS-1];
	column_word_t expected_columns [$];
	int           failures = 0;

	initial begin
		mismatch_count  = 0;
		pending_columns = 0;
	end

	always @(posedge clk or negedge arst_n) begin : track
		column_word_t seen;
		column_word_t want;
		logic [31:0]  remaining;
		logic [7:0]   col;
		int           pos;

		if (!arst_n) begin
			foreach (digit_image[p])
				digit_image[p] = 8'h00;
			expected_columns.delete();
		end else begin
			// Results are checked before the new item is predicted, so a column
			// that leaves in the same cycle is matched against older work.
			if (out_valid && out_ready) begin
				seen.grid   = grid_address;
				seen.column = segment_column;
				seen.last   = last;
				if (expected_columns.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected column: grid %0d column %02h last %0b",
							seen.grid, seen.column, seen.last);
				end else begin
					want = expected_columns.pop_front();
					if (seen.grid !== want.grid || seen.column !== want.column ||
							seen.last !== want.last) begin
						failures++;
						if (failures <= 10) begin
							$write("column mismatch: expected grid %0d column %02h last %0b,",
								want.grid, want.column, want.last);
							$display(" got grid %0d column %02h last %0b",
								seen.grid, seen.column, seen.last);
						end
					end
				end
			end

			if (in_valid && in_ready) begin
				if (kind == KIND_CLEAR) begin
					foreach (digit_image[p])
						digit_image[p] = 8'h00;
				end else begin
					// Least significant digit lands highest; positions past the
					// store are dropped but the division still moves on.
					remaining = value;
					for (int k = 0; k < int'(digit_count); k++) begin
						pos = int'(start_digit) + int'(digit_count) - 1 - k;
						if (pos < DSMW_DIGITS)
							digit_image[pos] = (leading_zeros || remaining != 0) ?
								SEGMENT_PATTERN[remaining % 10] : 8'h00;
						remaining = remaining / 10;
					end
					for (int r = 0; r < DSMW_ROWS; r++) begin
						for (int j = 0; j < 8; j++)
							col[7-j] = (j < DSMW_DIGITS) ? digit_image[j][r] : 1'b0;
						want.grid   = 4'(2 * r);
						want.column = col;
						want.last   = (r == DSMW_ROWS - 1);
						expected_columns.push_back(want);
					end
				end
			end
		end
		pending_columns <= expected_columns.size();
		mismatch_count  <= failures;
	end

endmodule

// ----- tb/decimal_segment_matrix_writer_tb.sv -----
// ----------------------------------------------------------------------------
// decimal_segment_matrix_writer_tb: self-checking bench for the matrix writer
// Drives directed and random show and clear items with random idle bursts on
// both channels and one long output hold-off; a checker module beside the
// block predicts every column byte and counts mismatches.
// ----------------------------------------------------------------------------
module decimal_segment_matrix_writer_tb;
	import dsmw_pkg::*;

	// A show item passes acceptance, its digit steps and eight column loads in the
	// block, and each of its eight columns may wait out a receiver burst, so even
	// the slowest legal run stays far below this limit.
	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS    = 445;
	localparam int CALM_ITEMS      = 60;
	localparam int DRAIN_CYCLES    = 40;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        kind           = KIND_SHOW;
	logic [2:0]  start_digit    = '0;
	logic        leading_zeros  = 1'b0;
	logic [3:0]  digit_count    = '0;
	logic [31:0] value          = '0;
	logic        out_ready      = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [3:0]  grid_address;
	logic [7:0]  segment_column;
	logic        last;

	int mismatch_count;
	int pending_columns;
	int cycles      = 0;
	// Set when the random part starts; the receiver then does its long hold-off.
	bit random_part = 1'b0;
	// Set for the closing stretch, where neither side idles.
	bit calm        = 1'b0;

	decimal_segment_matrix_writer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.start_digit    (start_digit),
		.leading_zeros  (leading_zeros),
		.digit_count    (digit_count),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.grid_address   (grid_address),
		.segment_column (segment_column),
		.last           (last)
	);

	dsmw_column_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.start_digit     (start_digit),
		.leading_zeros   (leading_zeros),
		.digit_count     (digit_count),
		.value           (value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.grid_address    (grid_address),
		.segment_column  (segment_column),
		.last            (last),
		.mismatch_count  (mismatch_count),
		.pending_columns (pending_columns)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here with the failing verdict.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offers one input transaction and returns at the edge that accepts it.
	// Outside the calm stretch a random idle burst may come first; otherwise
	// valid simply stays high into the next item with a fresh payload.
	task automatic offer_item(input logic k, input logic [2:0] s, input logic lz,
			input logic [3:0] n, input logic [31:0] v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= k;
		start_digit   <= s;
		leading_zeros <= lz;
		digit_count   <= n;
		value         <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Receiver. Once the random part begins it holds off for a long stretch
	// while the sender keeps offering, so the single output register fills
	// and the block stops taking input. After that it stalls in short random
	// bursts, and not at all during the calm stretch.
	initial begin : receiver
		bit hold_off_done;

		hold_off_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (random_part && !hold_off_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] v;
		logic [3:0]  n;
		logic        k;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A zero value without leading zeros blanks every
		// position, even the lowest one; with leading zeros it shows all zeros.
		offer_item(KIND_SHOW, 3'd0, 1'b0, 4'd8, 32'd0);
		offer_item(KIND_SHOW, 3'd0, 1'b1, 4'd8, 32'd0);
		// Largest value, every digit kept in the store.
		offer_item(KIND_SHOW, 3'd0, 1'b0, 4'd8, 32'hFFFF_FFFF);
		// Every digit from 0 to 9; the two lowest fall off the top of the store.
		offer_item(KIND_SHOW, 3'd0, 1'b1, 4'd10, 32'd1234567890);
		// Counts above eight: from the top position almost everything is dropped.
		offer_item(KIND_SHOW, 3'd7, 1'b1, 4'd15, 32'hFFFF_FFFF);
		offer_item(KIND_SHOW, 3'd0, 1'b1, 4'd15, 32'd4000000009);
		// Zero count writes nothing but still sends all eight columns.
		offer_item(KIND_SHOW, 3'd3, 1'b1, 4'd0, 32'd55);
		// Clear empties the store; the next show sees a blank store around it.
		offer_item(KIND_CLEAR, 3'd0, 1'b0, 4'd0, 32'd0);
		offer_item(KIND_SHOW, 3'd1, 1'b0, 4'd7, 32'd1234567);
		// Single digit in the top position.
		offer_item(KIND_SHOW, 3'd7, 1'b0, 4'd1, 32'd9);
		// Blanking above a short value, zeros inside the value still shown.
		offer_item(KIND_SHOW, 3'd5, 1'b0, 4'd3, 32'd42);
		offer_item(KIND_SHOW, 3'd0, 1'b0, 4'd8, 32'd100);
		// Run past the end of the store: the lowest four digits, then three, are dropped.
		offer_item(KIND_SHOW, 3'd4, 1'b1, 4'd8, 32'd12345678);
		offer_item(KIND_SHOW, 3'd2, 1'b0, 4'd9, 32'd5);
		// Two clears back to back, then a show of all eights.
		offer_item(KIND_CLEAR, 3'd7, 1'b1, 4'd15, 32'hFFFF_FFFF);
		offer_item(KIND_CLEAR, 3'd0, 1'b0, 4'd8, 32'd0);
		offer_item(KIND_SHOW, 3'd0, 1'b1, 4'd8, 32'd88888888);
		offer_item(KIND_SHOW, 3'd6, 1'b1, 4'd2, 32'd7);

		// Random part: mostly show items over a spread of value magnitudes,
		// with an occasional clear and the odd oversized count.
		random_part = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			case ($urandom_range(0, 5))
				0:       v = $urandom_range(0, 9);
				1:       v = $urandom_range(0, 99999);
				2:       v = 32'd0;
				3:       v = 32'hFFFF_FFFF - $urandom_range(0, 20);
				default: v = $urandom;
			endcase
			n = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) :
				4'($urandom_range(0, 8));
			k = ($urandom_range(0, 11) == 0) ? KIND_CLEAR : KIND_SHOW;
			offer_item(k, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), n, v);
		end
		in_valid <= 1'b0;

		// The checker's count is registered, so the bench steps the clock before waiting on it.
		@(posedge clk);
		while (pending_columns != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_columns == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
